### sv/sesc_pkg.sv
package sesc_pkg;

  localparam int unsigned SESC_MAX_LEN = 6;
  localparam int unsigned SESC_IDX_W   = $clog2(SESC_MAX_LEN);

  typedef logic [SESC_IDX_W-1:0] sesc_idx_t;

  // escape class of one raw byte
  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_LETTER,
    KIND_UNICODE,
    KIND_PREFIX
  } sesc_kind_t;

  // one output byte of the run, plus run length
  typedef struct packed {
    sesc_idx_t  len;
    logic [7:0] sym;
  } sesc_sel_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = CH_ZERO + {4'h0, nib};
    end else begin
      res = CH_UPPER_A + {4'h0, nib} - 8'd10;
    end
    return res;
  endfunction

endpackage

### sv/string_escape_encoder.sv
// String escape encoder: one raw string byte per item in, its escaped form out
// one byte per cycle. An item is taken when start is high and busy is low;
// results appear on out_* with out_valid high for exactly one cycle each and
// cannot be held off, so the receiver must take every byte as it comes.
// An accepted item passes the holding stage and the result register before its
// first result. A byte that passes unchanged gives one output byte, a two-byte
// escape two, a JSON \u00XX escape six; busy is high for all but the last
// cycle of a run, so plain bytes stream at one item per cycle, a figure set by
// the single output byte register. cfg_protocol_mode, loaded into mode_r on
// cfg_we, picks the syntax (0 s-expression, 1 JSON); mode_r is sampled per item.
module string_escape_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_data_byte,
  input  logic       in_string_last,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_end,
  input  logic       cfg_we,
  input  logic       cfg_protocol_mode
);
  import sesc_pkg::*;

  // mode register
  logic mode_r;

  // holding stage: item being expanded
  logic       hold_valid_r, hold_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       json_r, json_nxt;
  sesc_idx_t  idx_r, idx_nxt;

  // result register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_run_last_r;
  logic       out_string_end_r;

  sesc_sel_t  sel;
  logic       run_done;
  logic       accept;

  sesc_seq u_seq (
    .raw_byte (byte_r),
    .json     (json_r),
    .idx      (idx_r),
    .sel      (sel)
  );

  // last byte of the run is being registered for output this cycle; a new item may enter
  assign run_done = (idx_r == (sel.len - SESC_IDX_W'(1)));
  assign busy     = hold_valid_r && !run_done;
  assign accept   = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_protocol_mode;
    end
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    byte_nxt       = byte_r;
    last_nxt       = last_r;
    json_nxt       = json_r;
    idx_nxt        = idx_r;
    priority if (accept) begin
      hold_valid_nxt = 1'b1;
      byte_nxt       = in_data_byte;
      last_nxt       = in_string_last;
      json_nxt       = mode_r;
      idx_nxt        = '0;
    end else if (hold_valid_r && run_done) begin
      hold_valid_nxt = 1'b0;
    end else if (hold_valid_r) begin
      idx_nxt = idx_r + SESC_IDX_W'(1);
    end else begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    json_r <= json_nxt;
  end

  // result register: one escaped byte per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= hold_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r       <= sel.sym;
    out_run_last_r   <= run_done;
    out_string_end_r <= run_done && last_r;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_run_last   = out_run_last_r;
  assign out_string_end = out_string_end_r;

  // an accepted item shows its first byte after the holding stage and the result register
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted item produced no result");

  // string end only on the closing byte of a run
  a_end_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_run_last) |-> !out_string_end)
    else $error("string end flagged mid run");

  // a run is sent without gaps
  a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_run_last) |=> out_valid)
    else $error("gap inside escape run");

  // while busy the stage is still emitting
  a_busy_emits: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !$past(start && !busy))
    else $error("busy without output");

endmodule

### sv/sesc_seq.sv
module sesc_seq (
  input  logic [7:0]         raw_byte,
  input  logic               json,
  input  sesc_pkg::sesc_idx_t idx,
  output sesc_pkg::sesc_sel_t sel
);
  import sesc_pkg::*;

  logic [7:0] letter;
  sesc_kind_t kind;

  always_comb begin
    unique case (raw_byte)
      8'h08:   letter = json ? 8'h62 : 8'h00;  // b
      8'h0C:   letter = json ? 8'h66 : 8'h00;  // f
      8'h0A:   letter = 8'h6E;                 // n
      8'h0D:   letter = 8'h72;                 // r
      8'h09:   letter = 8'h74;                 // t
      default: letter = 8'h00;
    endcase
  end

  always_comb begin
    priority if (letter != 8'h00) begin
      kind = KIND_LETTER;
    end else if (json && (raw_byte < CH_CTRL_LIMIT)) begin
      kind = KIND_UNICODE;
    end else if ((raw_byte == CH_QUOTE) || (raw_byte == CH_BSLASH) ||
                 (json && (raw_byte == CH_SLASH))) begin
      kind = KIND_PREFIX;
    end else begin
      kind = KIND_PLAIN;
    end
  end

  always_comb begin
    sel.len = SESC_IDX_W'(1);
    sel.sym = raw_byte;
    unique case (kind)
      KIND_PLAIN: begin
        sel.len = SESC_IDX_W'(1);
        sel.sym = raw_byte;
      end
      KIND_LETTER: begin
        sel.len = SESC_IDX_W'(2);
        sel.sym = (idx == '0) ? CH_BSLASH : letter;
      end
      KIND_PREFIX: begin
        sel.len = SESC_IDX_W'(2);
        sel.sym = (idx == '0) ? CH_BSLASH : raw_byte;
      end
      KIND_UNICODE: begin
        sel.len = SESC_IDX_W'(SESC_MAX_LEN);
        unique case (idx)
          SESC_IDX_W'(0): sel.sym = CH_BSLASH;
          SESC_IDX_W'(1): sel.sym = CH_U;
          SESC_IDX_W'(4): sel.sym = hex_digit(raw_byte[7:4]);
          SESC_IDX_W'(5): sel.sym = hex_digit(raw_byte[3:0]);
          default:        sel.sym = CH_ZERO;
        endcase
      end
      default: begin
        sel.len = SESC_IDX_W'(1);
        sel.sym = raw_byte;
      end
    endcase
  end

endmodule
